### design/vasp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis sum projection package
// Shared widths, register indexes and axis codes of the projection core.
// ----------------------------------------------------------------------------
package vasp_pkg;

  localparam int SUM_W     = 24;
  localparam int COORD_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int AXIS_W    = 2;
  localparam int CFG_IDX_W = 2;

  // The fourth axis code is invalid and produces no results.
  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS   = 2'd0,
    REG_SIZE_X = 2'd1,
    REG_SIZE_Y = 2'd2,
    REG_SIZE_Z = 2'd3
  } cfg_reg_e;

endpackage

### design/vasp_acc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator memory
// Single-clock memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module vasp_acc_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // A read and a write of the same entry in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/volume_axis_sum_projection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume axis sum projection core
// Sums a raster-ordered voxel stream along the X, Y or Z axis and emits each
// completed sum together with its coordinates in the reduced image.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  --------------------------------
//  in       sink       in_valid_i / in_stall_o sample_i
//  out      source     out_valid_o/out_stall_i total_o, out_x_o, out_y_o,
//                                              out_z_o, volume_done_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The core takes one voxel per cycle when not stalled; the limit is the single
// read-modify-write of the accumulator memory, which a forwarding register
// keeps at one access per cycle even when neighboring voxels hit one entry.
// A result passes the index stages, the accumulate stage and the output
// register after its voxel's transfer. The index stages include RED_STEPS
// compare-and-subtract stages that reduce the accumulator index modulo PLANE_DEPTH (zero for the default parameters).
// Reset clears the position counters and the pipeline; the accumulator memory
// needs no clearing pass, since the first contribution of a sum overwrites it.
// The whole pipeline holds only while the output register carries a result
// that is stalled and the last stage has another one ready for it.
//
module volume_axis_sum_projection_core #(
  parameter int MAX_DIM     = 256,
  parameter int PLANE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Voxel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vasp_pkg::SUM_W-1:0]   total_o,
  output logic [vasp_pkg::COORD_W-1:0]        out_x_o,
  output logic [vasp_pkg::COORD_W-1:0]        out_y_o,
  output logic [vasp_pkg::COORD_W-1:0]        out_z_o,
  output logic                                volume_done_o,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vasp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vasp_pkg::SIZE_W-1:0]         cfg_data_i
);

  import vasp_pkg::*;

  // Counter width, and the width of a raw plane index row * size_x + col.
  localparam int CW = $clog2(MAX_DIM);
  localparam int VW = 2 * CW;
  localparam int PW = 2 * CW + 1;
  localparam int AW = $clog2(PLANE_DEPTH);
  localparam int XW = (VW > AW) ? VW : AW;
  localparam int EW = (SIZE_W > $clog2(MAX_DIM + 1)) ? SIZE_W : $clog2(MAX_DIM + 1);
  // Number of conditional subtractions that bring a raw index below PLANE_DEPTH.
  localparam int RED_STEPS = $clog2(((2 ** VW) + PLANE_DEPTH - 1) / PLANE_DEPTH);
  localparam int NSTG = 2 + RED_STEPS;
  localparam int LAST = NSTG - 1;

  typedef struct packed {
    logic                          valid;
    logic [AXIS_W-1:0]             mode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CW-1:0]                 col;
    logic [CW-1:0]                 row;
    logic [CW-1:0]                 slice;
    logic                          emit;
    logic                          done;
    logic                          first;
    logic [XW-1:0]                 val;
  } item_t;

  // Last index in use along one axis, with out-of-range sizes clamped.
  function automatic logic [CW-1:0] eff_last(input logic [SIZE_W-1:0] sz);
    logic [EW-1:0] s;
    s = EW'(sz);
    if (sz == '0) begin
      return '0;
    end else if (s > EW'(MAX_DIM)) begin
      return CW'(MAX_DIM - 1);
    end else begin
      return CW'(s - EW'(1));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // --------------------------------------------------------------------------
  logic [AXIS_W-1:0] axis_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXIS_X;
      size_x_q <= SIZE_W'(256);
      size_y_q <= SIZE_W'(256);
      size_z_q <= SIZE_W'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AXIS:   axis_q   <= cfg_data_i[AXIS_W-1:0];
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. Everything moves together unless a new result would
  // overwrite a stalled one in the output register.
  // --------------------------------------------------------------------------
  item_t pipe_q [NSTG];
  item_t m_q;
  logic  out_valid_q;
  logic  adv;
  logic  in_xfer;

  assign adv        = !(out_valid_q && out_stall_i && m_q.valid && m_q.emit);
  assign in_stall_o = !adv;
  assign in_xfer    = in_valid_i && adv;

  // --------------------------------------------------------------------------
  // Position counters and item decode at the input transfer.
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, row_q, slice_q;
  logic [CW-1:0] col_d, row_d, slice_d;
  logic [CW-1:0] last_x, last_y, last_z;
  logic [CW:0]   sx_eff;
  logic          last_col, last_row, last_slice;
  logic [PW-1:0] prod;
  item_t         in_item;

  assign last_x = eff_last(size_x_q);
  assign last_y = eff_last(size_y_q);
  assign last_z = eff_last(size_z_q);
  assign sx_eff = {1'b0, last_x} + (CW+1)'(1);

  // A counter beyond the last index, after a size was lowered, counts as last.
  assign last_col   = col_q >= last_x;
  assign last_row   = row_q >= last_y;
  assign last_slice = slice_q >= last_z;

  // Only the Z projection offsets the index by whole rows.
  assign prod = (axis_q == AXIS_Z) ? PW'(row_q) * PW'(sx_eff) : '0;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    slice_d = slice_q;
    if (!last_col) begin
      col_d = col_q + CW'(1);
    end else begin
      col_d = '0;
      if (!last_row) begin
        row_d = row_q + CW'(1);
      end else begin
        row_d = '0;
        if (!last_slice) begin
          slice_d = slice_q + CW'(1);
        end else begin
          slice_d = '0;
        end
      end
    end
  end

  always_comb begin
    in_item        = '0;
    in_item.valid  = in_xfer;
    in_item.mode   = axis_q;
    in_item.sample = sample_i;
    in_item.col    = col_q;
    in_item.row    = row_q;
    in_item.slice  = slice_q;
    in_item.done   = last_col && last_row && last_slice;
    in_item.val    = XW'(prod[VW-1:0]);
    case (axis_q)
      AXIS_X: begin
        in_item.emit  = last_col;
        in_item.first = col_q == '0;
      end
      AXIS_Y: begin
        in_item.emit  = last_row;
        in_item.first = row_q == '0;
      end
      AXIS_Z: begin
        in_item.emit  = last_slice;
        in_item.first = slice_q == '0;
      end
      default: begin
        in_item.emit  = 1'b0;
        in_item.first = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slice_q <= '0;
    end else if (in_xfer) begin
      col_q   <= col_d;
      row_q   <= row_d;
      slice_q <= slice_d;
    end
  end

  // --------------------------------------------------------------------------
  // Index pipeline: stage 0 holds the row offset, stage 1 adds the column and
  // the remaining stages reduce the index modulo PLANE_DEPTH, one subtraction
  // of a shifted PLANE_DEPTH per stage.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[0].valid <= 1'b0;
    end else if (adv) begin
      pipe_q[0] <= in_item;
    end
  end

  item_t stg1_d;

  always_comb begin
    stg1_d     = pipe_q[0];
    stg1_d.val = pipe_q[0].val + XW'(pipe_q[0].col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[1].valid <= 1'b0;
    end else if (adv) begin
      pipe_q[1] <= stg1_d;
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [XW-1:0] SubVal = XW'(PLANE_DEPTH) << (RED_STEPS - 1 - k);

    item_t red_d;

    always_comb begin
      red_d = pipe_q[k+1];
      if (pipe_q[k+1].val >= SubVal) begin
        red_d.val = pipe_q[k+1].val - SubVal;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[k+2].valid <= 1'b0;
      end else if (adv) begin
        pipe_q[k+2] <= red_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage. The last index stage issues the read; in m_q the item
  // adds its sample and writes the sum back (Y, Z) or to row_total_q (X). When
  // the item ahead writes the entry being read, its sum is forwarded instead.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] row_total_q;
  logic [SUM_W-1:0] fwd_data_q;
  logic             fwd_q;
  logic             fwd_d;
  logic             m_wr;
  logic [SUM_W-1:0] operand;
  logic [SUM_W-1:0] sum;

  assign m_wr  = m_q.valid && (m_q.mode == AXIS_Y || m_q.mode == AXIS_Z);
  assign fwd_d = m_wr && (m_q.val[AW-1:0] == pipe_q[LAST].val[AW-1:0]);

  always_comb begin
    case (m_q.mode)
      AXIS_X:         operand = row_total_q;
      AXIS_Y, AXIS_Z: operand = fwd_q ? fwd_data_q : rd_data;
      default:        operand = '0;
    endcase
    if (m_q.first) begin
      operand = '0;
    end
    sum = operand + SUM_W'($signed(m_q.sample));
  end

  vasp_acc_ram #(
    .DEPTH (PLANE_DEPTH),
    .WIDTH (SUM_W)
  ) u_acc_ram (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (pipe_q[LAST].val[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (adv && m_wr),
    .wr_addr_i (m_q.val[AW-1:0]),
    .wr_data_i (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q.valid <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (adv) begin
      m_q   <= pipe_q[LAST];
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_data_q <= sum;
    end
  end

  // The running row sum of the X projection lives in a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_total_q <= '0;
    end else if (adv && m_q.valid && m_q.mode == AXIS_X) begin
      row_total_q <= sum;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A waiting result is held until its transfer.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] total_q;
  logic [COORD_W-1:0]      out_x_q, out_y_q, out_z_q;
  logic                    volume_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && m_q.valid && m_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m_q.valid && m_q.emit) begin
      total_q       <= sum;
      out_x_q       <= (m_q.mode == AXIS_X) ? '0 : COORD_W'(m_q.col);
      out_y_q       <= (m_q.mode == AXIS_Y) ? '0 : COORD_W'(m_q.row);
      out_z_q       <= (m_q.mode == AXIS_Z) ? '0 : COORD_W'(m_q.slice);
      volume_done_q <= m_q.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign total_o       = total_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign volume_done_o = volume_done_q;

endmodule
